>>> hdl/nms_3x3_peak_detector_top_assert.svh
// assertion macros shared by the rtl
`ifndef NMS_3X3_PEAK_DETECTOR_TOP_ASSERT_SVH
`define NMS_3X3_PEAK_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define NMS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define NMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NMS_ASSERT(lbl, clk, rst_n, prop, msg)

`define NMS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> hdl/nms_pkg.sv
`default_nettype none

package nms_pkg;

  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int MAX_HEIGHT_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int FRAME_WIDTH_BITS  = 12;
  localparam int FRAME_HEIGHT_BITS = 13;
  localparam int RATIO_BITS        = 16;
  localparam int CFG_DATA_BITS     = 16;
  localparam int CFG_IDX_BITS      = 2;

  localparam int FRAME_WIDTH_RST  = 2048;
  localparam int FRAME_HEIGHT_RST = 4096;
  localparam int RATIO_RST        = 256;

  localparam int MIN_SIZE = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_RESIZE_RATIO = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> hdl/nms_if.sv
`default_nettype none

interface nms_in_if #(
  parameter int SAMPLE_BITS = nms_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface nms_out_if #(
  parameter int SAMPLE_BITS = nms_pkg::SAMPLE_BITS_DEF,
  parameter int COL_BITS    = $clog2(nms_pkg::MAX_WIDTH_DEF),
  parameter int ROW_BITS    = $clog2(nms_pkg::MAX_HEIGHT_DEF)
);
  logic                                    valid;
  logic                                    ready;
  logic        [COL_BITS-1:0]              peak_col;
  logic        [ROW_BITS-1:0]              peak_row;
  logic        [COL_BITS+nms_pkg::RATIO_BITS-1:0] scaled_x;
  logic        [ROW_BITS+nms_pkg::RATIO_BITS-1:0] scaled_y;
  logic signed [SAMPLE_BITS-1:0]           peak_value;

  modport source (output valid, output peak_col, output peak_row, output scaled_x,
                  output scaled_y, output peak_value, input ready);
  modport sink   (input valid, input peak_col, input peak_row, input scaled_x,
                  input scaled_y, input peak_value, output ready);
endinterface

`default_nettype wire

>>> hdl/nms_ram.sv
`default_nettype none

module nms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/nms_3x3_peak_detector_top.sv
// 3x3 non-maximum suppression over a raster stream of signed Q8.8 response samples. One
// sample word is taken every clock while ready is high; a peak word passes stages 1, 2 and 3
// after the sample below-right of its centre is taken. The two line stores are block RAMs
// with a registered read, read at the column of the incoming sample and written as that
// sample moves into the 3x3 window, so a frame width of three or more keeps read and write
// apart. Input ready falls only when every pipeline stage holds a word and the output word
// is not taken. A centre is a peak only when strictly above all eight neighbours; border
// pixels never report. The user writes frame size and resize ratio only while the block is
// idle, not enforced by the block; sizes below three act as three, above the maximum as the
// maximum. Line stores are not cleared, safe as windows reading unfilled lines never report.
`default_nettype none

module nms_3x3_peak_detector_top #(
  parameter int MAX_WIDTH   = nms_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = nms_pkg::MAX_HEIGHT_DEF,
  parameter int SAMPLE_BITS = nms_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  nms_in_if.sink                                  in_chan,
  nms_out_if.source                               out_chan,
  input  wire logic                               cfg_we,
  input  wire logic [nms_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  wire logic [nms_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  `include "nms_3x3_peak_detector_top_assert.svh"

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WSZ  = CW + 1;
  localparam int HSZ  = RW + 1;
  localparam int RB   = nms_pkg::RATIO_BITS;
  localparam int FWB  = nms_pkg::FRAME_WIDTH_BITS;
  localparam int FHB  = nms_pkg::FRAME_HEIGHT_BITS;
  localparam int WCMP = (WSZ > FWB) ? WSZ : FWB;
  localparam int HCMP = (HSZ > FHB) ? HSZ : FHB;
  localparam int FW_RST = (nms_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                          MAX_WIDTH : nms_pkg::FRAME_WIDTH_RST;
  localparam int FH_RST = (nms_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ?
                          MAX_HEIGHT : nms_pkg::FRAME_HEIGHT_RST;

  // configuration, sizes held already clamped
  logic [WSZ-1:0]  fw_r;
  logic [HSZ-1:0]  fh_r;
  logic [RB-1:0]   ratio_r;
  logic [WCMP-1:0] fw_raw;
  logic [HCMP-1:0] fh_raw;
  logic [WSZ-1:0]  fw_nxt;
  logic [HSZ-1:0]  fh_nxt;

  assign fw_raw = WCMP'(cfg_wdata[FWB-1:0]);
  assign fh_raw = HCMP'(cfg_wdata[FHB-1:0]);

  always_comb begin
    if (fw_raw < WCMP'(nms_pkg::MIN_SIZE)) begin
      fw_nxt = WSZ'(nms_pkg::MIN_SIZE);
    end else if (fw_raw > WCMP'(MAX_WIDTH)) begin
      fw_nxt = WSZ'(MAX_WIDTH);
    end else begin
      fw_nxt = WSZ'(fw_raw);
    end
    if (fh_raw < HCMP'(nms_pkg::MIN_SIZE)) begin
      fh_nxt = HSZ'(nms_pkg::MIN_SIZE);
    end else if (fh_raw > HCMP'(MAX_HEIGHT)) begin
      fh_nxt = HSZ'(MAX_HEIGHT);
    end else begin
      fh_nxt = HSZ'(fh_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r    <= WSZ'(FW_RST);
      fh_r    <= HSZ'(FH_RST);
      ratio_r <= RB'(nms_pkg::RATIO_RST);
    end else if (cfg_we) begin
      unique case (nms_pkg::cfg_reg_t'(cfg_idx))
        nms_pkg::CFG_FRAME_WIDTH:  fw_r    <= fw_nxt;
        nms_pkg::CFG_FRAME_HEIGHT: fh_r    <= fh_nxt;
        nms_pkg::CFG_RESIZE_RATIO: ratio_r <= cfg_wdata[RB-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic v1_r, v2_r, ov_r;
  logic adv1, adv2, adv3;
  logic in_acc;
  logic s1_move;

  assign adv3   = !ov_r || out_chan.ready;
  assign adv2   = !v2_r || adv3;
  assign adv1   = !v1_r || adv2;
  assign in_chan.ready = adv1;
  assign in_acc  = in_chan.valid && adv1;
  assign s1_move = v1_r && adv2;

  // position of the next sample
  logic [CW-1:0] col_cnt_r;
  logic [RW-1:0] row_cnt_r;
  logic          col_last;
  logic          row_last;
  logic          centre_ok;

  assign col_last  = (WSZ'(col_cnt_r) + WSZ'(1)) >= fw_r;
  assign row_last  = (HSZ'(row_cnt_r) + HSZ'(1)) >= fh_r;
  assign centre_ok = (col_cnt_r >= CW'(2)) && (row_cnt_r >= RW'(2)) &&
                     (WSZ'(col_cnt_r) < fw_r) && (HSZ'(row_cnt_r) < fh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_cnt_r <= '0;
        row_cnt_r <= row_last ? '0 : row_cnt_r + RW'(1);
      end else begin
        col_cnt_r <= col_cnt_r + CW'(1);
      end
    end
  end

  // stage 1: sample waits for the line store read
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic        [CW-1:0]          s1_col_r;
  logic        [RW-1:0]          s1_row_r;
  logic                          s1_chk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_chan.sample;
      s1_col_r    <= col_cnt_r;
      s1_row_r    <= row_cnt_r;
      s1_chk_r    <= centre_ok;
    end
  end

  logic [SAMPLE_BITS-1:0] up_rd;
  logic [SAMPLE_BITS-1:0] mid_rd;

  nms_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_col_r),
    .wdata (mid_rd),
    .re    (in_acc),
    .raddr (col_cnt_r),
    .rdata (up_rd)
  );

  nms_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_middle (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_col_r),
    .wdata (s1_sample_r),
    .re    (in_acc),
    .raddr (col_cnt_r),
    .rdata (mid_rd)
  );

  // window: [row][col], col 2 newest
  logic signed [SAMPLE_BITS-1:0] win_r   [3][3];
  logic signed [SAMPLE_BITS-1:0] win_nxt [3][3];
  logic signed [SAMPLE_BITS-1:0] centre;
  logic                          peak;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = signed'(up_rd);
    win_nxt[1][2] = signed'(mid_rd);
    win_nxt[2][2] = s1_sample_r;
    centre = win_nxt[1][1];
    peak   = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(i == 1 && j == 1) && !(centre > win_nxt[i][j])) begin
          peak = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (s1_move) begin
      win_r <= win_nxt;
    end
  end

  // stage 2: peak found
  logic        [CW-1:0]          p_col_r;
  logic        [RW-1:0]          p_row_r;
  logic signed [SAMPLE_BITS-1:0] p_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r && s1_chk_r && peak;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      p_col_r <= s1_col_r - CW'(1);
      p_row_r <= s1_row_r - RW'(1);
      p_val_r <= centre;
    end
  end

  // stage 3: scaling and output word
  logic        [CW-1:0]          o_col_r;
  logic        [RW-1:0]          o_row_r;
  logic        [CW+RB-1:0]       o_sx_r;
  logic        [RW+RB-1:0]       o_sy_r;
  logic signed [SAMPLE_BITS-1:0] o_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv3) begin
      ov_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && adv3) begin
      o_col_r <= p_col_r;
      o_row_r <= p_row_r;
      o_sx_r  <= (CW+RB)'(p_col_r) * (CW+RB)'(ratio_r);
      o_sy_r  <= (RW+RB)'(p_row_r) * (RW+RB)'(ratio_r);
      o_val_r <= p_val_r;
    end
  end

  assign out_chan.valid      = ov_r;
  assign out_chan.peak_col   = o_col_r;
  assign out_chan.peak_row   = o_row_r;
  assign out_chan.scaled_x   = o_sx_r;
  assign out_chan.scaled_y   = o_sy_r;
  assign out_chan.peak_value = o_val_r;

  `NMS_ASSERT(a_line_rw_apart, clk, rst_n, (s1_move && in_acc) |-> (s1_col_r != col_cnt_r), "line store read and write collide")
  `NMS_ASSERT(a_no_border_peak, clk, rst_n, ov_r |-> (o_col_r != '0 && o_row_r != '0), "peak reported on border")
  `NMS_ASSERT(a_stall_source, clk, rst_n, !in_chan.ready |-> (ov_r && !out_chan.ready && v1_r && v2_r), "input stalled with room in pipeline")
  `NMS_ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n) |-> (!ov_r && !v1_r && !v2_r), "pipeline not empty after reset")

endmodule

`default_nettype wire
